// ----- rtl/tes_pkg.sv -----
`timescale 1ns / 1ps

package tes_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int RESULT_WIDTH_DEF = 64;
  localparam int D_WIDTH          = 32;
  localparam int OUT_WIDTH        = 64;
  localparam int FRAC_SHIFT       = 15;
  localparam int NUM_COLS         = 6;
  localparam int CFG_INDEX_WIDTH  = 3;
  localparam int ROW_WIDTH        = 3;
  localparam int LANE_SPLIT       = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_D11 = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_D12 = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_D13 = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_D22 = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_D23 = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_D33 = 3'd5;

  localparam logic [ROW_WIDTH-1:0] LAST_ROW = 3'd5;

  typedef struct packed {
    logic start;
    logic degen;
    logic det_neg;
  } tes_lane_ctl_t;

endpackage

// ----- rtl/tes_lane.sv -----
`timescale 1ns / 1ps

module tes_lane #(
  parameter int COORD_WIDTH  = tes_pkg::COORD_WIDTH_DEF,
  parameter int RESULT_WIDTH = tes_pkg::RESULT_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  tes_pkg::tes_lane_ctl_t                        ctl,
  input  logic signed [COORD_WIDTH+tes_pkg::D_WIDTH+1:0] va,
  input  logic signed [COORD_WIDTH+tes_pkg::D_WIDTH+1:0] vb,
  input  logic signed [COORD_WIDTH:0]                   ta,
  input  logic signed [COORD_WIDTH:0]                   tb,
  input  logic        [2*COORD_WIDTH+2:0]               absdet,
  output logic                                          done,
  output logic signed [RESULT_WIDTH-1:0]                value
);

  localparam int DIFF = COORD_WIDTH + 1;
  localparam int VW   = DIFF + tes_pkg::D_WIDTH + 1;
  localparam int DETW = 2 * DIFF + 1;
  localparam int SPL  = tes_pkg::LANE_SPLIT;
  localparam int XW   = (VW - SPL > SPL + 1) ? VW - SPL : SPL + 1;
  localparam int PW   = XW + DIFF;
  localparam int NW   = VW + DIFF + 1;
  localparam int NDW  = NW + tes_pkg::FRAC_SHIFT;
  localparam int HW   = NDW - RESULT_WIDTH;
  localparam int RMW  = DETW + 1;
  localparam int CMPW = (HW > RMW) ? HW : RMW;
  localparam int CNTW = $clog2(RESULT_WIDTH);

  typedef enum logic [2:0] {L_IDLE, L_MAC, L_CHK, L_DIV, L_SAT, L_DONE} state_t;

  state_t                   state;
  logic [CNTW-1:0]          cnt;
  logic signed [NW-1:0]     acc;
  logic signed [NW-1:0]     prod;
  logic                     neg;
  logic [RMW-1:0]           rem;
  logic [RESULT_WIDTH-1:0]  lowbits;
  logic [RESULT_WIDTH-1:0]  quo;

  logic signed [XW-1:0]     xop;
  logic signed [DIFF-1:0]   top_sel;
  logic                     hi_part;
  logic signed [PW-1:0]     pr;
  logic signed [NW-1:0]     prod_next;
  logic [NW-1:0]            mag;
  logic [NDW-1:0]           num;
  logic [CMPW-1:0]          hi_ext;
  logic [CMPW-1:0]          det_ext;
  logic [RMW-1:0]           trial;
  logic [RESULT_WIDTH-1:0]  lim;

  always_comb begin
    xop     = '0;
    top_sel = ta;
    hi_part = 1'b0;
    case (cnt[1:0])
      2'd0: begin
        xop = XW'($signed({1'b0, va[SPL-1:0]}));
        top_sel = ta;
      end
      2'd1: begin
        xop = XW'(va[VW-1:SPL]);
        top_sel = ta;
        hi_part = 1'b1;
      end
      2'd2: begin
        xop = XW'($signed({1'b0, vb[SPL-1:0]}));
        top_sel = tb;
      end
      default: begin
        xop = XW'(vb[VW-1:SPL]);
        top_sel = tb;
        hi_part = 1'b1;
      end
    endcase
    pr        = xop * top_sel;
    prod_next = hi_part ? (NW'(pr) <<< SPL) : NW'(pr);
    mag       = acc[NW-1] ? (~acc + NW'(1)) : acc;
    num       = {mag, {tes_pkg::FRAC_SHIFT{1'b0}}};
    hi_ext    = CMPW'(num[NDW-1:RESULT_WIDTH]);
    det_ext   = CMPW'(absdet);
    trial     = {rem[RMW-2:0], lowbits[RESULT_WIDTH-1]};
    lim       = {1'b0, {(RESULT_WIDTH-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        L_IDLE, L_DONE: begin
          if (ctl.start) begin
            cnt <= '0;
            acc <= '0;
            if (ctl.degen) begin
              value <= '0;
              state <= L_DONE;
            end else begin
              state <= L_MAC;
            end
          end
        end
        L_MAC: begin
          prod <= prod_next;
          if (cnt != '0) begin
            acc <= acc + prod;
          end
          if (cnt == CNTW'(4)) begin
            state <= L_CHK;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        L_CHK: begin
          neg     <= acc[NW-1] ^ ctl.det_neg;
          rem     <= hi_ext[RMW-1:0];
          lowbits <= num[RESULT_WIDTH-1:0];
          quo     <= '0;
          cnt     <= '0;
          if (hi_ext >= det_ext) begin
            value <= (acc[NW-1] ^ ctl.det_neg) ? $signed(~lim) : $signed(lim);
            state <= L_DONE;
          end else begin
            state <= L_DIV;
          end
        end
        L_DIV: begin
          lowbits <= lowbits << 1;
          if (trial >= RMW'(absdet)) begin
            rem <= trial - RMW'(absdet);
            quo <= {quo[RESULT_WIDTH-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[RESULT_WIDTH-2:0], 1'b0};
          end
          if (cnt == CNTW'(RESULT_WIDTH - 1)) begin
            state <= L_SAT;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        L_SAT: begin
          if (!neg) begin
            value <= (quo > lim) ? $signed(lim) : $signed(quo);
          end else begin
            value <= (quo > lim + RESULT_WIDTH'(1)) ? $signed(~lim) : $signed(~quo + 1'b1);
          end
          state <= L_DONE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  assign done = (state == L_DONE);

endmodule

// ----- rtl/triangle_element_stiffness.sv -----
`timescale 1ns / 1ps

// Constant strain triangle stiffness: each transfer of three corners yields six row
// transfers of the 6x6 matrix K, row 0 first, last_row set on row 5. Six column lanes
// each run a four-step multiply-accumulate and a one-bit-per-cycle restoring divider by
// twice the signed area; the divider loop in the lanes sets the time a row takes while
// the output is not stalled. A zero-area row skips the lanes' multiply and divide. One item
// is buffered at the input while another is at work, and a finished row waits in the output
// register. A zero-area triangle gives six rows of zeros with degenerate set. The user must
// write the elasticity entries through the cfg port only while the block is idle; the block
// itself does not enforce this.

module triangle_element_stiffness #(
  parameter int COORD_WIDTH  = tes_pkg::COORD_WIDTH_DEF,
  parameter int RESULT_WIDTH = tes_pkg::RESULT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [tes_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [tes_pkg::D_WIDTH-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_WIDTH-1:0]          corner1_x,
  input  logic signed [COORD_WIDTH-1:0]          corner1_y,
  input  logic signed [COORD_WIDTH-1:0]          corner2_x,
  input  logic signed [COORD_WIDTH-1:0]          corner2_y,
  input  logic signed [COORD_WIDTH-1:0]          corner3_x,
  input  logic signed [COORD_WIDTH-1:0]          corner3_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [tes_pkg::ROW_WIDTH-1:0]          row_index,
  output logic signed [tes_pkg::OUT_WIDTH-1:0]   col0_value,
  output logic signed [tes_pkg::OUT_WIDTH-1:0]   col1_value,
  output logic signed [tes_pkg::OUT_WIDTH-1:0]   col2_value,
  output logic signed [tes_pkg::OUT_WIDTH-1:0]   col3_value,
  output logic signed [tes_pkg::OUT_WIDTH-1:0]   col4_value,
  output logic signed [tes_pkg::OUT_WIDTH-1:0]   col5_value,
  output logic                                   degenerate,
  output logic                                   last_row
);

  localparam int DIFF = COORD_WIDTH + 1;
  localparam int DW   = tes_pkg::D_WIDTH;
  localparam int PVW  = DIFF + DW;
  localparam int VW   = PVW + 1;
  localparam int PDW  = 2 * DIFF;
  localparam int DETW = PDW + 1;
  localparam int NC   = tes_pkg::NUM_COLS;

  typedef enum logic [2:0] {S_IDLE, S_DET, S_SUM, S_VMUL, S_VSUM, S_LANE, S_OUT} state_t;

  state_t state;

  logic signed [DW-1:0] d11, d12, d13, d22, d23, d33;
  logic signed [DW-1:0] dm [3][3];

  logic                          pend;
  logic signed [COORD_WIDTH-1:0] bx1, by1, bx2, by2, bx3, by3;

  logic signed [DIFF-1:0] bv [3];
  logic signed [DIFF-1:0] cv [3];
  logic signed [PDW-1:0]  p1, p2;
  logic [DETW-1:0]        absdet;
  logic                   det_neg;
  logic                   degen;
  logic [tes_pkg::ROW_WIDTH-1:0] row;
  logic signed [PVW-1:0]  vp0 [3];
  logic signed [PVW-1:0]  vp1 [3];
  logic signed [VW-1:0]   v [3];
  logic                   lane_start;

  logic signed [DETW-1:0] dsum;
  logic                   odd;
  logic [1:0]             node;
  logic signed [DIFF-1:0] t1, t2;
  logic                   row_drain;

  tes_pkg::tes_lane_ctl_t      ctl;
  logic [NC-1:0]               lane_done;
  logic signed [RESULT_WIDTH-1:0] lane_val [NC];
  logic signed [RESULT_WIDTH-1:0] col_r [NC];

  always_comb begin
    dm[0][0] = d11; dm[0][1] = d12; dm[0][2] = d13;
    dm[1][0] = d12; dm[1][1] = d22; dm[1][2] = d23;
    dm[2][0] = d13; dm[2][1] = d23; dm[2][2] = d33;
    dsum = DETW'(p1) - DETW'(p2);
    odd  = row[0];
    node = row[2:1];
    t1   = odd ? cv[node] : bv[node];
    t2   = odd ? bv[node] : cv[node];
    ctl.start   = lane_start;
    ctl.degen   = degen;
    ctl.det_neg = det_neg;
    row_drain   = !out_valid || out_ready;
  end

  assign in_ready = !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      d11 <= '0; d12 <= '0; d13 <= '0;
      d22 <= '0; d23 <= '0; d33 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        tes_pkg::REG_D11: d11 <= cfg_data;
        tes_pkg::REG_D12: d12 <= cfg_data;
        tes_pkg::REG_D13: d13 <= cfg_data;
        tes_pkg::REG_D22: d22 <= cfg_data;
        tes_pkg::REG_D23: d23 <= cfg_data;
        tes_pkg::REG_D33: d33 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
      lane_start <= 1'b0;
      row        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pend <= 1'b1;
        bx1 <= corner1_x; by1 <= corner1_y;
        bx2 <= corner2_x; by2 <= corner2_y;
        bx3 <= corner3_x; by3 <= corner3_y;
      end
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pend) begin
            pend  <= 1'b0;
            bv[0] <= DIFF'(by2) - DIFF'(by3);
            bv[1] <= DIFF'(by3) - DIFF'(by1);
            bv[2] <= DIFF'(by1) - DIFF'(by2);
            cv[0] <= DIFF'(bx3) - DIFF'(bx2);
            cv[1] <= DIFF'(bx1) - DIFF'(bx3);
            cv[2] <= DIFF'(bx2) - DIFF'(bx1);
            state <= S_DET;
          end
        end
        S_DET: begin
          p1    <= cv[2] * bv[1];
          p2    <= cv[1] * bv[2];
          state <= S_SUM;
        end
        S_SUM: begin
          absdet  <= dsum[DETW-1] ? (~dsum + DETW'(1)) : dsum;
          det_neg <= dsum[DETW-1];
          degen   <= (dsum == '0);
          row     <= '0;
          state   <= S_VMUL;
        end
        S_VMUL: begin
          for (int l = 0; l < 3; l++) begin
            vp0[l] <= t1 * (odd ? dm[1][l] : dm[0][l]);
            vp1[l] <= t2 * dm[2][l];
          end
          state <= S_VSUM;
        end
        S_VSUM: begin
          for (int l = 0; l < 3; l++) begin
            v[l] <= VW'(vp0[l]) + VW'(vp1[l]);
          end
          lane_start <= 1'b1;
          state      <= S_LANE;
        end
        S_LANE: begin
          lane_start <= 1'b0;
          if (!lane_start && (&lane_done)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (row_drain) begin
            out_valid <= 1'b1;
            row_index <= row;
            last_row  <= (row == tes_pkg::LAST_ROW);
            degenerate <= degen;
            for (int j = 0; j < NC; j++) begin
              col_r[j] <= lane_val[j];
            end
            if (row == tes_pkg::LAST_ROW) begin
              state <= S_IDLE;
            end else begin
              row   <= row + 1'b1;
              state <= S_VMUL;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar j = 0; j < NC; j++) begin : g_lane
    tes_lane #(
      .COORD_WIDTH  (COORD_WIDTH),
      .RESULT_WIDTH (RESULT_WIDTH)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .va     ((j % 2 == 0) ? v[0] : v[1]),
      .vb     (v[2]),
      .ta     ((j % 2 == 0) ? bv[j/2] : cv[j/2]),
      .tb     ((j % 2 == 0) ? cv[j/2] : bv[j/2]),
      .absdet (absdet),
      .done   (lane_done[j]),
      .value  (lane_val[j])
    );
  end

  assign col0_value = tes_pkg::OUT_WIDTH'(col_r[0]);
  assign col1_value = tes_pkg::OUT_WIDTH'(col_r[1]);
  assign col2_value = tes_pkg::OUT_WIDTH'(col_r[2]);
  assign col3_value = tes_pkg::OUT_WIDTH'(col_r[3]);
  assign col4_value = tes_pkg::OUT_WIDTH'(col_r[4]);
  assign col5_value = tes_pkg::OUT_WIDTH'(col_r[5]);

endmodule

// ----- dv/triangle_element_stiffness_tb.sv -----
`timescale 1ns / 1ps

module triangle_element_stiffness_tb;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [tes_pkg::ROW_WIDTH-1:0] row;
    logic [5:0][tes_pkg::OUT_WIDTH-1:0] col;
    logic degen;
    logic last;
  } k_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [tes_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [tes_pkg::D_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] corner1_x = '0, corner1_y = '0, corner2_x = '0;
  logic signed [31:0] corner2_y = '0, corner3_x = '0, corner3_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [tes_pkg::ROW_WIDTH-1:0] row_index;
  logic signed [tes_pkg::OUT_WIDTH-1:0] col0_value, col1_value, col2_value;
  logic signed [tes_pkg::OUT_WIDTH-1:0] col3_value, col4_value, col5_value;
  logic degenerate, last_row;

  logic signed [31:0] material [6];
  k_row_t stiffness_rows [$];
  int errors = 0;
  int cycles = 0;
  int triangles_sent = 0;
  int rows_checked = 0;
  int degenerate_seen = 0;
  bit no_idle = 1'b0;
  int stall_left = 0;

  triangle_element_stiffness uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .corner1_x(corner1_x), .corner1_y(corner1_y),
    .corner2_x(corner2_x), .corner2_y(corner2_y),
    .corner3_x(corner3_x), .corner3_y(corner3_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .row_index(row_index),
    .col0_value(col0_value), .col1_value(col1_value), .col2_value(col2_value),
    .col3_value(col3_value), .col4_value(col4_value), .col5_value(col5_value),
    .degenerate(degenerate), .last_row(last_row)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows pending", cycles, stiffness_rows.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver side stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  function automatic void predict_element(logic signed [31:0] c [6]);
    logic signed [191:0] x [3], y [3], bu [3][6], dm [3][3];
    logic signed [191:0] det, n, q, hi_lim, lo_lim;
    k_row_t r;
    int a, b;
    hi_lim = (192'sd1 <<< 63) - 192'sd1;
    lo_lim = -(192'sd1 <<< 63);
    for (int i = 0; i < 3; i++) begin
      x[i] = c[2*i];
      y[i] = c[2*i+1];
    end
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      b = (i + 2) % 3;
      bu[0][2*i] = y[a] - y[b]; bu[0][2*i+1] = '0;
      bu[1][2*i] = '0;          bu[1][2*i+1] = x[b] - x[a];
      bu[2][2*i] = x[b] - x[a]; bu[2][2*i+1] = y[a] - y[b];
    end
    dm[0][0] = material[tes_pkg::REG_D11];
    dm[0][1] = material[tes_pkg::REG_D12]; dm[1][0] = material[tes_pkg::REG_D12];
    dm[0][2] = material[tes_pkg::REG_D13]; dm[2][0] = material[tes_pkg::REG_D13];
    dm[1][1] = material[tes_pkg::REG_D22];
    dm[1][2] = material[tes_pkg::REG_D23]; dm[2][1] = material[tes_pkg::REG_D23];
    dm[2][2] = material[tes_pkg::REG_D33];
    det = (x[1] - x[0]) * (y[2] - y[0]) - (x[2] - x[0]) * (y[1] - y[0]);
    for (int i = 0; i < 6; i++) begin
      r.row = tes_pkg::ROW_WIDTH'(i);
      r.degen = (det == 0);
      r.last = (i == 5);
      for (int j = 0; j < 6; j++) begin
        if (det == 0) begin
          r.col[j] = '0;
        end else begin
          n = '0;
          for (int k = 0; k < 3; k++)
            for (int l = 0; l < 3; l++)
              n = n + bu[k][i] * dm[k][l] * bu[l][j];
          n = n <<< tes_pkg::FRAC_SHIFT;
          q = n / det;
          if (q > hi_lim) q = hi_lim;
          else if (q < lo_lim) q = lo_lim;
          r.col[j] = q[63:0];
        end
      end
      stiffness_rows.push_back(r);
    end
  endfunction

  task automatic send_triangle(logic signed [31:0] x1, y1, x2, y2, x3, y3);
    logic signed [31:0] c [6];
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    corner1_x <= x1; corner1_y <= y1;
    corner2_x <= x2; corner2_y <= y2;
    corner3_x <= x3; corner3_y <= y3;
    do @(posedge clk); while (!in_ready);
    c = '{x1, y1, x2, y2, x3, y3};
    predict_element(c);
    triangles_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (stiffness_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // all six entries, then two writes to unused indexes that must be ignored
  task automatic set_material(logic signed [31:0] d11, d12, d13, d22, d23, d33);
    logic signed [31:0] v [6];
    v = '{d11, d12, d13, d22, d23, d33};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= tes_pkg::CFG_INDEX_WIDTH'(i);
      cfg_data <= v[i];
      material[i] = v[i];
      @(posedge clk);
    end
    cfg_index <= 3'd6;
    cfg_data <= $urandom();
    @(posedge clk);
    cfg_index <= 3'd7;
    cfg_data <= $urandom();
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report(string what, logic [63:0] e, logic [63:0] a);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %h actual %h", what, e, a);
  endtask

  always @(posedge clk) begin
    k_row_t e;
    logic [5:0][tes_pkg::OUT_WIDTH-1:0] got;
    if (!rst && out_valid && out_ready) begin
      got = {col5_value, col4_value, col3_value, col2_value, col1_value, col0_value};
      if (stiffness_rows.size() == 0) begin
        report("unexpected row transfer", '0, 64'(row_index));
      end else begin
        e = stiffness_rows.pop_front();
        rows_checked++;
        if (degenerate) degenerate_seen++;
        if (row_index !== e.row) report("row_index", 64'(e.row), 64'(row_index));
        for (int j = 0; j < 6; j++)
          if (got[j] !== e.col[j]) report($sformatf("row %0d col%0d", e.row, j), e.col[j], got[j]);
        if (degenerate !== e.degen) report("degenerate", 64'(e.degen), 64'(degenerate));
        if (last_row !== e.last) report("last_row", 64'(e.last), 64'(last_row));
      end
    end
  end

  localparam logic signed [31:0] MAXC = 32'sh7fffffff;
  localparam logic signed [31:0] MINC = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  task automatic test_reset_material();
    send_triangle(0, 0, ONE, 0, 0, ONE);
    send_triangle(MAXC, MINC, MINC, 0, 0, MAXC);
    drain();
  endtask

  task automatic test_degenerate();
    set_material(32'sh00100000, 32'sh00030000, 0, 32'sh00100000, 0, 32'sh00068000);
    send_triangle(ONE, ONE, ONE, ONE, ONE, ONE);
    send_triangle(0, 0, ONE, ONE, 2 * ONE, 2 * ONE);
    send_triangle(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
    send_triangle(MINC, MINC, 0, 0, MAXC, MAXC - 1 + 1);
    drain();
  endtask

  task automatic test_extremes();
    send_triangle(0, 0, ONE, 0, 0, ONE);
    send_triangle(0, 0, 0, ONE, ONE, 0);
    send_triangle(MINC, MINC, MAXC, MINC, MINC, MAXC);
    send_triangle(MAXC, MAXC, MINC, MAXC, MAXC, MINC);
    send_triangle(MINC, MAXC, MAXC, MINC, 0, 0);
    send_triangle(0, 0, 1, 0, 0, 1);
    send_triangle(-1, -1, 32'sh12345678, -32'sh5a5a5a5a, MINC, 3);
    drain();
    set_material(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC);
    send_triangle(0, 0, 1, 0, 0, 1);
    send_triangle(0, 0, 0, 1, 1, 0);
    send_triangle(MINC, MINC, MAXC, MINC, MINC, MAXC);
    drain();
    set_material(MINC, MINC, MINC, MINC, MINC, MINC);
    send_triangle(0, 0, 1, 0, 0, 1);
    send_triangle(0, 0, MAXC, 0, 0, MAXC);
    send_triangle(ONE, 0, 0, ONE, 0, 0);
    drain();
    set_material(MAXC, MINC, 0, MINC, MAXC, -1);
    send_triangle(0, 0, ONE, 0, 0, ONE);
    send_triangle(MAXC, 0, MINC, MAXC, 0, MINC);
    drain();
  endtask

  function automatic logic signed [31:0] rand_small();
    return $signed($urandom_range(0, 32'h003fffff)) - 32'sh00200000;
  endfunction

  task automatic test_random(int count);
    logic signed [31:0] p [6];
    int mode, k;
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3)
        set_material($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      else
        set_material($urandom_range(0, 32'h00ffffff), rand_small(), rand_small(),
                     $urandom_range(0, 32'h00ffffff), rand_small(), $urandom_range(0, 32'h007fffff));
      no_idle = (phase == 1);
      for (int n = 0; n < count / 4; n++) begin
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 6; i++)
          p[i] = (mode < 5) ? rand_small() : $urandom();
        if (mode == 9) begin
          k = $urandom_range(0, 3);
          p[4] = p[0] + k * (p[2] - p[0]);
          p[5] = p[1] + k * (p[3] - p[1]);
        end
        send_triangle(p[0], p[1], p[2], p[3], p[4], p[5]);
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 6; i++) material[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_reset_material();
    test_degenerate();
    test_extremes();
    test_random(440);
    $display("sent %0d triangles over several material settings, checked %0d rows",
             triangles_sent, rows_checked);
    $display("%0d degenerate rows seen, %0d mismatches", degenerate_seen, errors);
    if (errors == 0 && stiffness_rows.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
